@@ design/crsp_pkg.sv @@
// ----------------------------------------------------------------------------
// crsp_pkg
// Types and constants shared by the coastline ring stream parser.
// ----------------------------------------------------------------------------
package crsp_pkg;

    typedef enum logic [2:0] {
        PH_COUNT    = 3'd0,
        PH_LEVEL    = 3'd1,
        PH_NCOUNT   = 3'd2,
        PH_LON      = 3'd3,
        PH_LAT      = 3'd4,
        PH_FINISHED = 3'd5,
        PH_STOPPED  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_POINT     = 3'd1,
        KIND_FINISHED  = 3'd2,
        KIND_BADCOUNT  = 3'd3,
        KIND_TRUNCATED = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  level;
        logic [31:0] point_count;
        logic [31:0] lon_bits;
        logic [31:0] lat_bits;
        logic        last;
    } result_t;

    // result queue: four entries, input taken while two are free
    localparam int QDEPTH  = 4;
    localparam int QCNT_W  = 3;
    localparam logic [QCNT_W-1:0] QACCEPT_MAX = 3'd2;

    localparam result_t RESULT_ZERO = '{
        kind:        KIND_HEADER,
        level:       8'd0,
        point_count: 32'd0,
        lon_bits:    32'd0,
        lat_bits:    32'd0,
        last:        1'b0
    };

endpackage

@@ design/coastline_ring_stream_parser.sv @@
// ----------------------------------------------------------------------------
// coastline_ring_stream_parser
// Byte-serial parser for a coastline buffer: ring count, then per ring a
// level, a point count and raw lon/lat word pairs.
// ----------------------------------------------------------------------------
// Takes one byte per clock. Each byte is decoded in the cycle it is
// accepted and yields up to two results, which go into a four-entry result
// queue that drains one word per cycle on the output side. A byte is
// accepted whenever at least two queue entries are free, so the input runs
// at one byte per cycle for as long as the output keeps taking results; a
// stalled output holds the input back once the queue holds three results.
// Write total_length (cfg channel) only while the parser is idle; unenforced.
module coastline_ring_stream_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] total_length,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  level,
    output logic [31:0] point_count,
    output logic [31:0] lon_bits,
    output logic [31:0] lat_bits,
    output logic        last
);

    crsp_pkg::phase_t  phase_reg,  phase_next;
    logic [1:0]        bcnt_reg,   bcnt_next;
    logic [23:0]       asm_reg,    asm_next;
    logic [31:0]       lon_reg,    lon_next;
    logic [31:0]       rings_reg,  rings_next;
    logic [31:0]       points_reg, points_next;
    logic [31:0]       pos_reg,    pos_next;
    logic [7:0]        lvl_reg,    lvl_next;
    logic [31:0]       tlen_reg;

    crsp_pkg::result_t q_reg [crsp_pkg::QDEPTH];
    crsp_pkg::result_t q_next [crsp_pkg::QDEPTH];
    logic [crsp_pkg::QCNT_W-1:0] qcnt_reg, qcnt_next;

    logic        accept;
    logic        active;
    logic        final_byte;
    logic        word_done;
    logic [31:0] word;
    logic [31:0] left;
    logic        bad;
    logic        ring_last;

    logic              main_v, fin_v, trunc_v;
    crsp_pkg::result_t main_r, fin_r, trunc_r;
    crsp_pkg::result_t rec0, rec1;
    logic              push0, push1;
    logic              pop;
    logic [crsp_pkg::QCNT_W-1:0] base;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (qcnt_reg <= crsp_pkg::QACCEPT_MAX);
    assign accept     = in_valid && in_ready;
    assign active     = (phase_reg != crsp_pkg::PH_FINISHED)
                     && (phase_reg != crsp_pkg::PH_STOPPED)
                     && (pos_reg < tlen_reg) && accept;
    assign final_byte = ((pos_reg + 32'd1) == tlen_reg);
    assign word_done  = (bcnt_reg == 2'd3);
    assign word       = {data_byte, asm_reg};
    // bytes left after this byte; position < length holds whenever active
    assign left       = tlen_reg - pos_reg - 32'd1;
    assign bad        = ({word, 3'b000} > {3'b000, left});
    assign ring_last  = (rings_reg == 32'd1);

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        bcnt_next   = bcnt_reg;
        asm_next    = asm_reg;
        lon_next    = lon_reg;
        rings_next  = rings_reg;
        points_next = points_reg;
        pos_next    = pos_reg;
        lvl_next    = lvl_reg;
        if (active)
        begin
            pos_next  = pos_reg + 32'd1;
            bcnt_next = bcnt_reg + 2'd1;
            case (bcnt_reg)
                2'd0:    asm_next[7:0]   = data_byte;
                2'd1:    asm_next[15:8]  = data_byte;
                2'd2:    asm_next[23:16] = data_byte;
                default: asm_next        = 24'd0;
            endcase
            case (phase_reg)
                crsp_pkg::PH_COUNT:
                begin
                    if (word_done)
                    begin
                        rings_next = word;
                        phase_next = (word == 32'd0) ? crsp_pkg::PH_FINISHED
                                                     : crsp_pkg::PH_LEVEL;
                    end
                end
                crsp_pkg::PH_LEVEL:
                begin
                    lvl_next   = data_byte;
                    asm_next   = 24'd0;
                    bcnt_next  = 2'd0;
                    phase_next = crsp_pkg::PH_NCOUNT;
                end
                crsp_pkg::PH_NCOUNT:
                begin
                    if (word_done)
                    begin
                        if (bad)
                        begin
                            phase_next = crsp_pkg::PH_STOPPED;
                        end
                        else if (word == 32'd0)
                        begin
                            points_next = word;
                            rings_next  = rings_reg - 32'd1;
                            phase_next  = ring_last ? crsp_pkg::PH_FINISHED
                                                    : crsp_pkg::PH_LEVEL;
                        end
                        else
                        begin
                            points_next = word;
                            phase_next  = crsp_pkg::PH_LON;
                        end
                    end
                end
                crsp_pkg::PH_LON:
                begin
                    if (word_done)
                    begin
                        lon_next   = word;
                        phase_next = crsp_pkg::PH_LAT;
                    end
                end
                crsp_pkg::PH_LAT:
                begin
                    if (word_done)
                    begin
                        points_next = points_reg - 32'd1;
                        if (points_reg == 32'd1)
                        begin
                            rings_next = rings_reg - 32'd1;
                            phase_next = ring_last ? crsp_pkg::PH_FINISHED
                                                   : crsp_pkg::PH_LEVEL;
                        end
                        else
                        begin
                            phase_next = crsp_pkg::PH_LON;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (final_byte && (phase_next != crsp_pkg::PH_FINISHED)
                && (phase_next != crsp_pkg::PH_STOPPED))
            begin
                phase_next = crsp_pkg::PH_STOPPED;
            end
        end
    end

    // results of this byte
    always_comb
    begin
        main_v  = 1'b0;
        fin_v   = 1'b0;
        main_r  = crsp_pkg::RESULT_ZERO;
        fin_r   = crsp_pkg::RESULT_ZERO;
        trunc_r = crsp_pkg::RESULT_ZERO;
        fin_r.kind   = crsp_pkg::KIND_FINISHED;
        trunc_r.kind = crsp_pkg::KIND_TRUNCATED;
        if (active && word_done)
        begin
            case (phase_reg)
                crsp_pkg::PH_COUNT:
                begin
                    main_v      = (word == 32'd0);
                    main_r.kind = crsp_pkg::KIND_FINISHED;
                end
                crsp_pkg::PH_NCOUNT:
                begin
                    main_v             = 1'b1;
                    main_r.kind        = bad ? crsp_pkg::KIND_BADCOUNT
                                             : crsp_pkg::KIND_HEADER;
                    main_r.level       = lvl_reg;
                    main_r.point_count = word;
                    fin_v              = !bad && (word == 32'd0) && ring_last;
                end
                crsp_pkg::PH_LAT:
                begin
                    main_v          = 1'b1;
                    main_r.kind     = crsp_pkg::KIND_POINT;
                    main_r.lon_bits = lon_reg;
                    main_r.lat_bits = word;
                    fin_v           = (points_reg == 32'd1) && ring_last;
                end
                default:
                begin
                    main_v = 1'b0;
                end
            endcase
        end
    end

    assign trunc_v = active && final_byte
                  && (phase_next == crsp_pkg::PH_STOPPED)
                  && !(main_v && (main_r.kind == crsp_pkg::KIND_BADCOUNT));

    always_comb
    begin
        rec0  = main_v ? main_r : (fin_v ? fin_r : trunc_r);
        rec1  = (main_v && fin_v) ? fin_r : trunc_r;
        push0 = main_v || fin_v || trunc_v;
        push1 = (main_v && (fin_v || trunc_v)) || (fin_v && trunc_v);
        rec0.last = !push1;
        rec1.last = 1'b1;
    end

    // result queue, head at entry 0
    assign pop  = (qcnt_reg != '0) && out_ready;
    assign base = qcnt_reg - {{(crsp_pkg::QCNT_W-1){1'b0}}, pop};

    always_comb
    begin
        for (int i = 0; i < crsp_pkg::QDEPTH; i++)
        begin
            if (pop && (i < crsp_pkg::QDEPTH - 1))
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (push0 && (base == crsp_pkg::QCNT_W'(i)))
            begin
                q_next[i] = rec0;
            end
            if (push1 && (base + 3'd1 == crsp_pkg::QCNT_W'(i)))
            begin
                q_next[i] = rec1;
            end
        end
        qcnt_next = base + {2'b00, push0} + {2'b00, push1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= crsp_pkg::PH_COUNT;
            bcnt_reg   <= 2'd0;
            asm_reg    <= 24'd0;
            rings_reg  <= 32'd0;
            points_reg <= 32'd0;
            pos_reg    <= 32'd0;
            lvl_reg    <= 8'd0;
            tlen_reg   <= 32'd0;
            qcnt_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            bcnt_reg   <= bcnt_next;
            asm_reg    <= asm_next;
            rings_reg  <= rings_next;
            points_reg <= points_next;
            pos_reg    <= pos_next;
            lvl_reg    <= lvl_next;
            qcnt_reg   <= qcnt_next;
            if (cfg_valid && cfg_ready)
            begin
                tlen_reg <= total_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lon_reg <= lon_next;
        for (int i = 0; i < crsp_pkg::QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    assign out_valid   = (qcnt_reg != '0);
    assign kind        = q_reg[0].kind;
    assign level       = q_reg[0].level;
    assign point_count = q_reg[0].point_count;
    assign lon_bits    = q_reg[0].lon_bits;
    assign lat_bits    = q_reg[0].lat_bits;
    assign last        = q_reg[0].last;

    // checks
    a_qcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= crsp_pkg::QCNT_W'(crsp_pkg::QDEPTH))
        else $error("result queue count out of range");

    a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == crsp_pkg::PH_FINISHED |=> phase_reg == crsp_pkg::PH_FINISHED)
        else $error("parser left finished state");

    a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == crsp_pkg::PH_STOPPED |=> phase_reg == crsp_pkg::PH_STOPPED)
        else $error("parser left stopped state");

    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(pos_reg))
        else $error("position moved without a byte");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == crsp_pkg::KIND_FINISHED
                      || kind == crsp_pkg::KIND_BADCOUNT
                      || kind == crsp_pkg::KIND_TRUNCATED) |-> last)
        else $error("terminal result not flagged last");

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the coastline ring stream parser.
// ----------------------------------------------------------------------------
// One coastline buffer is streamed through the parser after a single reset.
// It opens with a short table of hand-written bytes, then carries random
// rings, and closes on a finish, a bad count or a truncation picked at random.
// Every accepted byte goes through a local decoder, and each output word is
// compared with the oldest expected word. The buffer length is rewritten
// while the parser is quiet, including pauses where bytes fall past the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int RING_TOTAL = 48;

    typedef enum int {
        END_FINISHED,
        END_BADCOUNT,
        END_TRUNCATED
    } ending_t;

    typedef struct {
        bit                 typed;
        int                 n;
        crsp_pkg::result_t  r;
    } byte_tag_t;

    typedef struct {
        bit                 set_len;
        logic [31:0]        len;
        logic [7:0]         b;
        bit                 typed;
        int                 n;
        crsp_pkg::result_t  r;
    } dir_row_t;

    localparam crsp_pkg::result_t HDR_FF_EMPTY = '{kind: crsp_pkg::KIND_HEADER,
        level: 8'hFF, point_count: 32'd0, lon_bits: 32'd0, lat_bits: 32'd0,
        last: 1'b1};
    localparam crsp_pkg::result_t HDR_00_ONE = '{kind: crsp_pkg::KIND_HEADER,
        level: 8'h00, point_count: 32'd1, lon_bits: 32'd0, lat_bits: 32'd0,
        last: 1'b1};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] total_length = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  level;
    logic [31:0] point_count;
    logic [31:0] lon_bits;
    logic [31:0] lat_bits;
    logic        last;

    // decoder state
    crsp_pkg::phase_t pstate = crsp_pkg::PH_COUNT;
    logic [2:0]  field_idx = 3'd0;
    logic [63:0] shift_acc = 64'd0;
    logic [31:0] rings_rem = 32'd0;
    logic [31:0] pts_rem = 32'd0;
    logic [31:0] parse_pos = 32'd0;
    logic [7:0]  ring_lvl = 8'd0;
    logic [31:0] buf_len = 32'd0;

    crsp_pkg::result_t step_results [$];
    crsp_pkg::result_t pending_results [$];
    byte_tag_t   byte_tags [$];
    logic [7:0]  ring_bytes [$];

    int          mismatches = 0;
    int          bytes_in = 0;
    int          kind_tally [5] = '{0, 0, 0, 0, 0};
    int          idle_mode = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        holding = 1'b0;

    dir_row_t dir_rows [24] = '{
        '{1'b1, 32'd0,         8'hFF, 1'b1, 0, crsp_pkg::RESULT_ZERO},  // length 0: dropped
        '{1'b0, 32'd0,         8'h00, 1'b1, 0, crsp_pkg::RESULT_ZERO},
        '{1'b1, 32'hFFFF_FFFF, 8'(RING_TOTAL), 1'b1, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b1, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b1, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b1, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'hFF, 1'b1, 0, crsp_pkg::RESULT_ZERO},  // empty ring
        '{1'b0, 32'd0,         8'h00, 1'b1, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b1, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b1, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b1, 1, HDR_FF_EMPTY},
        '{1'b0, 32'd0,         8'h00, 1'b1, 0, crsp_pkg::RESULT_ZERO},  // one-point ring
        '{1'b0, 32'd0,         8'h01, 1'b1, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b1, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b1, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b1, 1, HDR_00_ONE},
        '{1'b0, 32'd0,         8'hFF, 1'b0, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'hFF, 1'b0, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'hFF, 1'b0, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'hFF, 1'b0, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b0, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b0, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b0, 0, crsp_pkg::RESULT_ZERO},
        '{1'b0, 32'd0,         8'h00, 1'b0, 0, crsp_pkg::RESULT_ZERO}
    };

    coastline_ring_stream_parser DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .total_length (total_length),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .level        (level),
        .point_count  (point_count),
        .lon_bits     (lon_bits),
        .lat_bits     (lat_bits),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic crsp_pkg::result_t mk_result(input crsp_pkg::kind_t k,
                                                    input logic [7:0] l,
                                                    input logic [31:0] c,
                                                    input logic [31:0] lon,
                                                    input logic [31:0] lat);
        crsp_pkg::result_t r;
        r = crsp_pkg::RESULT_ZERO;
        r.kind = k;
        r.level = l;
        r.point_count = c;
        r.lon_bits = lon;
        r.lat_bits = lat;
        return r;
    endfunction

    // little-endian word assembly; true once four bytes are in
    function automatic bit shift_in(input logic [7:0] b);
        shift_acc = shift_acc | (64'(b) << (8 * field_idx[1:0]));
        field_idx = field_idx + 3'd1;
        if (field_idx >= 3'd4)
        begin
            field_idx = 3'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void close_ring();
        rings_rem = rings_rem - 32'd1;
        if (rings_rem == 32'd0)
        begin
            step_results.insert(step_results.size(),
                mk_result(crsp_pkg::KIND_FINISHED, 8'd0, 32'd0, 32'd0, 32'd0));
            pstate = crsp_pkg::PH_FINISHED;
        end
        else
            pstate = crsp_pkg::PH_LEVEL;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        logic        at_end;
        logic [31:0] cnt;
        logic [31:0] room;
        step_results.delete();
        if (pstate > crsp_pkg::PH_LAT || parse_pos >= buf_len)
            return;
        at_end = (parse_pos + 32'd1 == buf_len);
        parse_pos = parse_pos + 32'd1;
        case (pstate)
            crsp_pkg::PH_COUNT:
                if (shift_in(b))
                begin
                    rings_rem = shift_acc[31:0];
                    shift_acc = 64'd0;
                    if (rings_rem == 32'd0)
                    begin
                        step_results.insert(step_results.size(),
                            mk_result(crsp_pkg::KIND_FINISHED, 8'd0, 32'd0, 32'd0, 32'd0));
                        pstate = crsp_pkg::PH_FINISHED;
                    end
                    else
                        pstate = crsp_pkg::PH_LEVEL;
                end
            crsp_pkg::PH_LEVEL:
            begin
                ring_lvl = b;
                shift_acc = 64'd0;
                field_idx = 3'd0;
                pstate = crsp_pkg::PH_NCOUNT;
            end
            crsp_pkg::PH_NCOUNT:
                if (shift_in(b))
                begin
                    cnt = shift_acc[31:0];
                    room = (buf_len > parse_pos) ? buf_len - parse_pos : 32'd0;
                    shift_acc = 64'd0;
                    if (({3'b000, cnt} << 3) > {3'b000, room})
                    begin
                        step_results.insert(step_results.size(),
                            mk_result(crsp_pkg::KIND_BADCOUNT, ring_lvl, cnt, 32'd0, 32'd0));
                        pstate = crsp_pkg::PH_STOPPED;
                    end
                    else
                    begin
                        step_results.insert(step_results.size(),
                            mk_result(crsp_pkg::KIND_HEADER, ring_lvl, cnt, 32'd0, 32'd0));
                        pts_rem = cnt;
                        if (cnt == 32'd0)
                            close_ring();
                        else
                            pstate = crsp_pkg::PH_LON;
                    end
                end
            crsp_pkg::PH_LON:
                if (shift_in(b))
                begin
                    shift_acc = {shift_acc[31:0], 32'd0};
                    pstate = crsp_pkg::PH_LAT;
                end
            crsp_pkg::PH_LAT:
                if (shift_in(b))
                begin
                    step_results.insert(step_results.size(),
                        mk_result(crsp_pkg::KIND_POINT, 8'd0, 32'd0,
                                  shift_acc[63:32], shift_acc[31:0]));
                    shift_acc = 64'd0;
                    pts_rem = pts_rem - 32'd1;
                    if (pts_rem == 32'd0)
                        close_ring();
                    else
                        pstate = crsp_pkg::PH_LON;
                end
            default:
                ;
        endcase
        if (at_end && pstate <= crsp_pkg::PH_LAT)
        begin
            step_results.insert(step_results.size(),
                mk_result(crsp_pkg::KIND_TRUNCATED, 8'd0, 32'd0, 32'd0, 32'd0));
            pstate = crsp_pkg::PH_STOPPED;
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void show_mismatch(input crsp_pkg::result_t want);
        $display("Mismatch at %0t", $time);
        $display("  exp kind=%0d level=%02h count=%08h lon=%08h lat=%08h last=%0b",
                 want.kind, want.level, want.point_count,
                 want.lon_bits, want.lat_bits, want.last);
        $display("  got kind=%0d level=%02h count=%08h lon=%08h lat=%08h last=%0b",
                 kind, level, point_count, lon_bits, lat_bits, last);
    endfunction

    always @(posedge clk)
    begin : scoreboard
        byte_tag_t         tag;
        crsp_pkg::result_t seen;
        crsp_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                buf_len = total_length;
            if (in_valid && in_ready)
            begin
                tag = byte_tags.pop_front();
                decode_byte(data_byte);
                bytes_in++;
                if (tag.typed)
                begin
                    if (tag.n != 0)
                        pending_results.insert(pending_results.size(), tag.r);
                end
                else
                    foreach (step_results[i])
                        pending_results.insert(pending_results.size(), step_results[i]);
            end
            if (out_valid && out_ready)
            begin
                seen = '{kind: crsp_pkg::kind_t'(kind), level: level,
                         point_count: point_count, lon_bits: lon_bits,
                         lat_bits: lat_bits, last: last};
                if (kind < 3'd5)
                    kind_tally[kind]++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected word at %0t: kind=%0d level=%02h count=%08h",
                                 $time, kind, level, point_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            show_mismatch(want);
                    end
                end
            end
        end
    end

    always @(posedge clk)
        out_ready <= !holding && ($urandom_range(0, 99) >= rx_idle_pct);

    // long output stall once the sender stops idling
    initial
    begin : rx_pressure
        wait (idle_mode == 2);
        @(posedge clk);
        holding <= 1'b1;
        repeat (400) @(posedge clk);
        holding <= 1'b0;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic set_idle(input int m);
        idle_mode = m;
        case (m)
            0:
            begin
                tx_idle_pct = 38;
                rx_idle_pct = 81;
            end
            1:
            begin
                tx_idle_pct = 81;
                rx_idle_pct = 38;
            end
            default:
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input int n,
                             input crsp_pkg::result_t r);
        byte_tag_t tag;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        tag.typed = typed;
        tag.n = n;
        tag.r = r;
        byte_tags.insert(byte_tags.size(), tag);
        in_valid <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending and wait for the output side to drain
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_length(input logic [31:0] v);
        settle();
        cfg_valid <= 1'b1;
        total_length <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic void pack_ring(input logic [7:0] lvl, input logic [31:0] cnt,
                                      input int pts);
        logic [31:0] w;
        ring_bytes.insert(ring_bytes.size(), lvl);
        for (int i = 0; i < 4; i++)
            ring_bytes.insert(ring_bytes.size(), cnt[8*i +: 8]);
        for (int p = 0; p < 2 * pts; p++)
        begin
            w = $urandom();
            for (int i = 0; i < 4; i++)
                ring_bytes.insert(ring_bytes.size(), w[8*i +: 8]);
        end
    endfunction

    task automatic send_ring();
        while (ring_bytes.size() != 0)
            send_byte(ring_bytes.pop_front(), 1'b0, 0, crsp_pkg::RESULT_ZERO);
    endtask

    function automatic int pick_points();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70)
            return int'($urandom_range(0, 3));
        else if (r < 95)
            return int'($urandom_range(4, 8));
        return int'($urandom_range(9, 20));
    endfunction

    initial
    begin : stimulus
        int      rings_sent;
        int      mode_now;
        int      na;
        int      nb;
        int      k;
        int      t;
        ending_t ending;
        set_idle(0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_len)
                write_length(dir_rows[i].len);
            send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].n, dir_rows[i].r);
        end
        rings_sent = 2;

        while (rings_sent < RING_TOTAL - 2)
        begin
            mode_now = (rings_sent - 2) * 3 / (RING_TOTAL - 4);
            if (mode_now != idle_mode)
            begin
                // pull the length back to the current position: bytes fall past the end
                settle();
                write_length(parse_pos);
                repeat (3)
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 0, crsp_pkg::RESULT_ZERO);
                write_length(32'hFFFF_FFFF);
                set_idle(mode_now);
            end
            na = pick_points();
            pack_ring(8'($urandom_range(0, 255)), 32'(na), na);
            send_ring();
            rings_sent++;
        end

        // last two rings, with the length set to force the chosen ending
        ending = ending_t'($urandom_range(0, 2));
        na = pick_points();
        settle();
        case (ending)
            END_FINISHED:
            begin
                nb = $urandom_range(0, 3);
                write_length(parse_pos + 32'(5 + 8 * na) + 32'(5 + 8 * nb));
                pack_ring(8'($urandom_range(0, 255)), 32'(na), na);
                pack_ring(8'($urandom_range(0, 255)), 32'(nb), nb);
            end
            END_BADCOUNT:
            begin
                k = $urandom_range(0, 3);
                write_length(parse_pos + 32'(5 + 8 * na) + 32'(5 + 8 * k));
                pack_ring(8'($urandom_range(0, 255)), 32'(na), na);
                pack_ring(8'($urandom_range(0, 255)),
                          $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'(k + 1), 0);
            end
            default:
            begin
                t = $urandom_range(0, 4);
                nb = $urandom_range(0, 3);
                write_length(parse_pos + 32'(5 + 8 * na) + 32'(t));
                pack_ring(8'($urandom_range(0, 255)), 32'(na), na);
                pack_ring(8'($urandom_range(0, 255)), 32'(nb), nb);
            end
        endcase
        send_ring();
        repeat (6)
            send_byte(8'($urandom_range(0, 255)), 1'b0, 0, crsp_pkg::RESULT_ZERO);

        settle();
        repeat (12) @(posedge clk);

        $display("Streamed %0d bytes over %0d rings, length rewrites, output stall, %s ending",
                 bytes_in, RING_TOTAL, ending.name());
        $display("Compared %0d words: %0d headers, %0d points, %0d finished, %0d bad, %0d truncated",
                 kind_tally[0] + kind_tally[1] + kind_tally[2] + kind_tally[3] + kind_tally[4],
                 kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], kind_tally[4]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
design/crsp_pkg.sv
design/coastline_ring_stream_parser.sv
tb/sv/tb_top.sv
